// File: hdl/hvn_pkg.sv
// hvn_pkg: shared types and constants of the heightmap vertex normal generator.
// Used by every module under hdl/; depends on nothing.
package hvn_pkg;

  // Grid coordinates cover a grid of up to 4096 vertices a side
  localparam int COORD_W   = 12;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORLD_Z     = 2'd3;

  // Input item kinds (tuser)
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Stream widths
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 216;

  // Shared bit-serial divider lanes
  localparam int DIV_NUM_W = 48;
  localparam int DIV_DEN_W = 34;
  localparam int DIV_LANES = 8;

  // Job queue between front and back
  localparam int JOB_Q_DEPTH = 4;

  // Slope saturation, 2^31-1
  localparam logic [30:0] SLOPE_MAX = 31'h7FFF_FFFF;
  localparam logic [14:0] NORM_MAX  = 15'h7FFF;

  // Grid configuration as the datapath sees it (sizes kept as size minus one)
  typedef struct packed {
    logic [COORD_W-1:0] w1;
    logic [COORD_W-1:0] h1;
    logic [CFG_W-1:0]   wsx;
    logic [CFG_W-1:0]   wsz;
  } grid_cfg_t;

  // One vertex to compute: its place and its five neighborhood heights
  typedef struct packed {
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  z;
    logic [SAMPLE_W-1:0] lv;
    logic [SAMPLE_W-1:0] cv;
    logic [SAMPLE_W-1:0] rv;
    logic [SAMPLE_W-1:0] tv;
    logic [SAMPLE_W-1:0] bv;
    logic                last;
  } vtx_job_t;

endpackage

// File: hdl/hvn_fifo.sv
// hvn_fifo: short queue of vertex jobs between the front and the back.
// Depends on hvn_pkg (vtx_job_t, JOB_Q_DEPTH).
module hvn_fifo import hvn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  vtx_job_t din,
  output logic     full,
  input  logic     pop,
  output vtx_job_t dout,
  output logic     empty
);

  localparam int PW = $clog2(JOB_Q_DEPTH);

  vtx_job_t        slots [JOB_Q_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full  = (count == (PW+1)'(JOB_Q_DEPTH));
  assign empty = (count == '0);
  assign dout  = slots[rd_ptr];

  // Payload slots
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && !empty) rd_ptr <= rd_ptr + 1'b1;
      unique case ({push && !full, pop && !empty})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hdl/hvn_div.sv
// hvn_div: one bit-serial divider lane, round to nearest: (num + den/2) / den.
// Depends on hvn_pkg (DIV_NUM_W, DIV_DEN_W). One quotient bit per cycle.
module hvn_div import hvn_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 busy,
  output logic [DIV_NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(DIV_NUM_W + 1);

  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem;
  logic [CNT_W-1:0]     cnt;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 fits;

  // Dividend bits shift out of quo while quotient bits shift in
  assign rem_sh = {rem, quo[DIV_NUM_W-1]};
  assign fits   = (rem_sh >= {1'b0, den_r});
  assign busy   = (cnt != '0);

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num + DIV_NUM_W'(den >> 1);
      den_r <= den;
      rem   <= '0;
    end else if (busy) begin
      rem <= fits ? DIV_DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIV_DEN_W-1:0];
      quo <= {quo[DIV_NUM_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DIV_NUM_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// File: hdl/hvn_front.sv
// hvn_front: accepts height items, keeps the two line stores and the raster
// counters, and queues vertex jobs with their neighborhood. Depends on hvn_pkg.
module hvn_front import hvn_pkg::*; #(
  parameter int MAX_W = 1024,
  parameter int MAX_H = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic [COORD_W-1:0]  w1,
  input  logic [COORD_W-1:0]  h1,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [SAMPLE_W-1:0] in_sample,
  input  logic                q_full,
  output logic                q_push,
  output vtx_job_t            q_job
);

  localparam int AW    = $clog2(MAX_W);
  localparam int RW    = $clog2(MAX_H + 1);
  localparam int CMP_W = COORD_W + 2;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_LEFT = 2'd1;
  localparam logic [1:0] F_END  = 2'd2;

  logic [1:0]          state;
  logic [AW-1:0]       column_count;
  logic [RW-1:0]       row_count;
  logic [AW-1:0]       cur_c;
  logic [RW-1:0]       cur_r;
  logic [SAMPLE_W-1:0] cur_s;
  logic                cur_flush;

  logic [SAMPLE_W-1:0] center_mem [MAX_W];
  logic [SAMPLE_W-1:0] upper_mem  [MAX_W];
  logic [SAMPLE_W-1:0] rd_center;
  logic [SAMPLE_W-1:0] rd_upper;
  logic [SAMPLE_W-1:0] prev_center;
  logic [SAMPLE_W-1:0] prev_upper;
  logic [SAMPLE_W-1:0] left_center;
  logic [SAMPLE_W-1:0] held_lower_sample;

  logic                wrap;
  logic [AW-1:0]       c_eff;
  logic [RW-1:0]       r_eff;
  logic                flush_eff;
  logic                accept;
  logic                has_a;
  logic                has_b;
  logic                end_row;
  logic                go;
  logic                mem_we;
  logic [AW-1:0]       mem_addr;
  logic [SAMPLE_W-1:0] mem_center_wd;
  logic [SAMPLE_W-1:0] mem_upper_wd;

  // Position of the arriving item, restarted if the counts ran past the grid
  assign wrap = (CMP_W'(column_count) > CMP_W'(w1)) ||
                (CMP_W'(row_count) > CMP_W'(h1) + CMP_W'(1));
  assign c_eff     = wrap ? '0 : column_count;
  assign r_eff     = wrap ? '0 : row_count;
  assign flush_eff = (CMP_W'(r_eff) > CMP_W'(h1));

  assign in_ready = (state == F_IDLE);
  assign accept   = in_valid && in_ready;

  assign has_a   = (cur_c != '0) && (cur_r != '0);
  assign has_b   = (cur_r != '0);
  assign end_row = (CMP_W'(cur_c) == CMP_W'(w1));

  // A step waits only when it has a job to queue and the queue is full
  always_comb begin
    go = 1'b0;
    case (state)
      F_LEFT:  go = !has_a || !q_full;
      F_END:   go = !has_b || !q_full;
      default: go = 1'b0;
    endcase
  end

  // Job assembly: left vertex of the pair, then the row-end vertex
  always_comb begin
    q_job  = '0;
    q_push = 1'b0;
    if (state == F_LEFT) begin
      q_push     = go && has_a;
      q_job.x    = COORD_W'(cur_c - 1'b1);
      q_job.z    = COORD_W'(cur_r - 1'b1);
      q_job.cv   = prev_center;
      q_job.lv   = (cur_c == AW'(1)) ? prev_center : left_center;
      q_job.rv   = rd_center;
      q_job.tv   = (cur_r == RW'(1)) ? prev_center : prev_upper;
      q_job.bv   = cur_flush ? prev_center : held_lower_sample;
      q_job.last = !end_row;
    end else if (state == F_END) begin
      q_push     = go && has_b;
      q_job.x    = COORD_W'(cur_c);
      q_job.z    = COORD_W'(cur_r - 1'b1);
      q_job.cv   = rd_center;
      q_job.lv   = left_center;
      q_job.rv   = rd_center;
      q_job.tv   = (cur_r == RW'(1)) ? rd_center : rd_upper;
      q_job.bv   = cur_flush ? rd_center : cur_s;
      q_job.last = 1'b1;
    end
  end

  // Line store update: the left column in F_LEFT, the row-end column in F_END
  always_comb begin
    mem_we        = 1'b0;
    mem_addr      = cur_c;
    mem_center_wd = held_lower_sample;
    mem_upper_wd  = prev_center;
    if (state == F_LEFT) begin
      mem_we   = go && !cur_flush && (cur_c != '0);
      mem_addr = cur_c - 1'b1;
    end else if (state == F_END) begin
      mem_we        = go && !cur_flush;
      mem_center_wd = cur_s;
      mem_upper_wd  = rd_center;
    end
  end

  // Center row store
  always_ff @(posedge clk) begin
    if (mem_we) center_mem[mem_addr] <= mem_center_wd;
    if (accept) rd_center <= center_mem[c_eff];
  end

  // Upper row store
  always_ff @(posedge clk) begin
    if (mem_we) upper_mem[mem_addr] <= mem_upper_wd;
    if (accept) rd_upper <= upper_mem[c_eff];
  end

  // Item registers and neighborhood registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_c     <= c_eff;
      cur_r     <= r_eff;
      cur_s     <= in_sample;
      cur_flush <= flush_eff;
    end
    if (state == F_LEFT && go) begin
      if (cur_c != '0) left_center <= prev_center;
      if (!end_row) begin
        prev_center <= rd_center;
        prev_upper  <= rd_upper;
      end
    end
  end

  // Sequencer and raster counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= F_IDLE;
      column_count      <= '0;
      row_count         <= '0;
      held_lower_sample <= '0;
    end else begin
      case (state)
        F_IDLE: begin
          if (accept) begin
            column_count <= c_eff;
            row_count    <= r_eff;
            // an item of the wrong kind for this phase is dropped
            if (flush_eff == in_op) state <= F_LEFT;
          end
        end
        F_LEFT: begin
          if (go) begin
            if (end_row) begin
              state <= F_END;
            end else begin
              if (!cur_flush) held_lower_sample <= cur_s;
              column_count <= cur_c + 1'b1;
              state        <= F_IDLE;
            end
          end
        end
        F_END: begin
          if (go) begin
            column_count <= '0;
            row_count    <= cur_flush ? '0 : cur_r + 1'b1;
            state        <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
      if (restart) begin
        column_count <= '0;
        row_count    <= '0;
      end
    end
  end

endmodule

// File: hdl/hvn_back.sv
// hvn_back: computes one vertex per job: position, UVs, slopes, square root
// and normalized normal. Depends on hvn_pkg and hvn_div (eight lanes).
module hvn_back import hvn_pkg::*; #(
  parameter int FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  grid_cfg_t             cfg,
  input  logic                  job_valid,
  input  vtx_job_t              job,
  output logic                  job_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data,
  output logic                  out_last
);

  localparam logic [3:0] B_IDLE  = 4'd0;
  localparam logic [3:0] B_MUL   = 4'd1;
  localparam logic [3:0] B_LOAD1 = 4'd2;
  localparam logic [3:0] B_DIV1  = 4'd3;
  localparam logic [3:0] B_GRAD  = 4'd4;
  localparam logic [3:0] B_SQ    = 4'd5;
  localparam logic [3:0] B_SUM   = 4'd6;
  localparam logic [3:0] B_ROOT  = 4'd7;
  localparam logic [3:0] B_LOAD2 = 4'd8;
  localparam logic [3:0] B_DIV2  = 4'd9;
  localparam logic [3:0] B_NORM  = 4'd10;
  localparam logic [3:0] B_OUT   = 4'd11;

  logic [3:0]     state;
  vtx_job_t       job_r;

  // Products and signs for the first divider pass
  logic [27:0]    mul_gx, mul_gz;
  logic           neg_gx, neg_gz, zero_gx, zero_gz;
  logic [24:0]    den_gx, den_gz;
  logic [36:0]    mul_px, mul_pz;
  logic           neg_px, neg_pz;
  logic [35:0]    mul_tu, mul_tv;
  logic [19:0]    vertex_index;

  // Slopes and normalization
  logic [30:0]    gx_mag, gz_mag;
  logic [61:0]    sqx, sqz;
  logic [63:0]    rad;
  logic [32:0]    rem;
  logic [31:0]    root;
  logic [4:0]     step;

  // Result registers
  logic [23:0]    pos_x, pos_z;
  logic [15:0]    pos_y;
  logic [15:0]    normal_x, normal_z;
  logic [14:0]    normal_y;
  logic [21:0]    tile_u, tile_v;
  logic [16:0]    unit_u, unit_v;

  // Divider lanes
  logic [DIV_NUM_W-1:0] lane_num [DIV_LANES];
  logic [DIV_DEN_W-1:0] lane_den [DIV_LANES];
  logic [DIV_NUM_W-1:0] lane_quo [DIV_LANES];
  logic [DIV_LANES-1:0] lane_busy;
  logic                 div_start;

  // Combinational helpers for the setup step
  logic [16:0]    dhx, dhz;
  logic [15:0]    dhx_mag, dhz_mag;
  logic [13:0]    d2x, d2z;
  logic [12:0]    d2x_mag, d2z_mag;
  logic           span2_x, span2_z;
  logic [24:0]    vi_prod;
  logic [34:0]    rem_sh;
  logic [34:0]    trial;

  assign dhx     = {job_r.rv[15], job_r.rv} - {job_r.lv[15], job_r.lv};
  assign dhz     = {job_r.bv[15], job_r.bv} - {job_r.tv[15], job_r.tv};
  assign dhx_mag = dhx[16] ? 16'(17'd0 - dhx) : dhx[15:0];
  assign dhz_mag = dhz[16] ? 16'(17'd0 - dhz) : dhz[15:0];
  assign d2x     = {1'b0, job_r.x, 1'b0} - {2'b00, cfg.w1};
  assign d2z     = {1'b0, job_r.z, 1'b0} - {2'b00, cfg.h1};
  assign d2x_mag = d2x[13] ? 13'(14'd0 - d2x) : d2x[12:0];
  assign d2z_mag = d2z[13] ? 13'(14'd0 - d2z) : d2z[12:0];
  // Span of two cells inside the grid, one at a border
  assign span2_x = (job_r.x != '0) && (job_r.x != cfg.w1);
  assign span2_z = (job_r.z != '0) && (job_r.z != cfg.h1);
  assign vi_prod = job_r.z * ({1'b0, cfg.w1} + 13'd1);

  // Square root, two radicand bits per step
  assign rem_sh = {rem, rad[63:62]};
  assign trial  = {1'b0, root, 2'b01};

  assign div_start = (state == B_LOAD1) || (state == B_LOAD2);
  assign job_pop   = (state == B_IDLE) && job_valid;

  // Lane operands: first pass slopes, positions, UVs; second pass normal terms
  always_comb begin
    for (int i = 0; i < DIV_LANES; i++) begin
      lane_num[i] = '0;
      lane_den[i] = DIV_DEN_W'(1);
    end
    if (state == B_LOAD1) begin
      lane_num[0] = DIV_NUM_W'({mul_gx, 16'd0});
      lane_den[0] = DIV_DEN_W'(den_gx);
      lane_num[1] = DIV_NUM_W'({mul_gz, 16'd0});
      lane_den[1] = DIV_DEN_W'(den_gz);
      lane_num[2] = DIV_NUM_W'(mul_px);
      lane_den[2] = DIV_DEN_W'({cfg.w1, 1'b0});
      lane_num[3] = DIV_NUM_W'(mul_pz);
      lane_den[3] = DIV_DEN_W'({cfg.h1, 1'b0});
      lane_num[4] = DIV_NUM_W'(mul_tu);
      lane_den[4] = DIV_DEN_W'({cfg.w1, 2'b00});
      lane_num[5] = DIV_NUM_W'(mul_tv);
      lane_den[5] = DIV_DEN_W'({cfg.h1, 2'b00});
      lane_num[6] = DIV_NUM_W'({job_r.x, 16'd0});
      lane_den[6] = DIV_DEN_W'(cfg.w1);
      lane_num[7] = DIV_NUM_W'({job_r.z, 16'd0});
      lane_den[7] = DIV_DEN_W'(cfg.h1);
    end else begin
      lane_num[0] = DIV_NUM_W'(gx_mag) << FRAC_BITS;
      lane_den[0] = DIV_DEN_W'(root);
      lane_num[1] = DIV_NUM_W'(gz_mag) << FRAC_BITS;
      lane_den[1] = DIV_DEN_W'(root);
      lane_num[2] = DIV_NUM_W'(1) << (16 + FRAC_BITS);
      lane_den[2] = DIV_DEN_W'(root);
    end
  end

  for (genvar g = 0; g < DIV_LANES; g++) begin : g_lane
    hvn_div u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (lane_num[g]),
      .den   (lane_den[g]),
      .busy  (lane_busy[g]),
      .quo   (lane_quo[g])
    );
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (job_valid) job_r <= job;
      end
      B_MUL: begin
        mul_gx       <= dhx_mag * cfg.w1;
        mul_gz       <= dhz_mag * cfg.h1;
        neg_gx       <= dhx[16];
        neg_gz       <= dhz[16];
        zero_gx      <= (dhx == '0);
        zero_gz      <= (dhz == '0);
        den_gx       <= span2_x ? {cfg.wsx, 1'b0} : {1'b0, cfg.wsx};
        den_gz       <= span2_z ? {cfg.wsz, 1'b0} : {1'b0, cfg.wsz};
        mul_px       <= cfg.wsx * d2x_mag;
        mul_pz       <= cfg.wsz * d2z_mag;
        neg_px       <= d2x[13];
        neg_pz       <= d2z[13];
        mul_tu       <= job_r.x * cfg.wsx;
        mul_tv       <= job_r.z * cfg.wsz;
        vertex_index <= 20'(vi_prod) + 20'(job_r.x);
        pos_y        <= job_r.cv;
      end
      B_GRAD: begin
        // slope saturates; a zero extent gives the largest slope of its sign
        if (zero_gx) gx_mag <= '0;
        else if (den_gx == '0 || (|lane_quo[0][DIV_NUM_W-1:31])) gx_mag <= SLOPE_MAX;
        else gx_mag <= lane_quo[0][30:0];
        if (zero_gz) gz_mag <= '0;
        else if (den_gz == '0 || (|lane_quo[1][DIV_NUM_W-1:31])) gz_mag <= SLOPE_MAX;
        else gz_mag <= lane_quo[1][30:0];
        pos_x  <= neg_px ? 24'(24'd0 - lane_quo[2][23:0]) : lane_quo[2][23:0];
        pos_z  <= neg_pz ? 24'(24'd0 - lane_quo[3][23:0]) : lane_quo[3][23:0];
        tile_u <= lane_quo[4][21:0];
        tile_v <= lane_quo[5][21:0];
        unit_u <= lane_quo[6][16:0];
        unit_v <= lane_quo[7][16:0];
      end
      B_SQ: begin
        sqx <= gx_mag * gx_mag;
        sqz <= gz_mag * gz_mag;
      end
      B_SUM: begin
        rad  <= 64'(sqx) + 64'(sqz) + (64'd1 << 32);
        rem  <= '0;
        root <= '0;
      end
      B_ROOT: begin
        if (rem_sh >= trial) begin
          rem  <= 33'(rem_sh - trial);
          root <= {root[30:0], 1'b1};
        end else begin
          rem  <= rem_sh[32:0];
          root <= {root[30:0], 1'b0};
        end
        rad <= {rad[61:0], 2'b00};
      end
      B_NORM: begin
        // normal points against the slope
        normal_x <= neg_gx ? {1'b0, (|lane_quo[0][DIV_NUM_W-1:15]) ? NORM_MAX : lane_quo[0][14:0]}
                           : 16'(16'd0 - {1'b0, (|lane_quo[0][DIV_NUM_W-1:15]) ? NORM_MAX
                                                                            : lane_quo[0][14:0]});
        normal_z <= neg_gz ? {1'b0, (|lane_quo[1][DIV_NUM_W-1:15]) ? NORM_MAX : lane_quo[1][14:0]}
                           : 16'(16'd0 - {1'b0, (|lane_quo[1][DIV_NUM_W-1:15]) ? NORM_MAX
                                                                            : lane_quo[1][14:0]});
        normal_y <= (|lane_quo[2][DIV_NUM_W-1:15]) ? NORM_MAX : lane_quo[2][14:0];
      end
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      step  <= '0;
    end else begin
      case (state)
        B_IDLE:  if (job_valid) state <= B_MUL;
        B_MUL:   state <= B_LOAD1;
        B_LOAD1: state <= B_DIV1;
        B_DIV1:  if (lane_busy == '0) state <= B_GRAD;
        B_GRAD:  state <= B_SQ;
        B_SQ:    state <= B_SUM;
        B_SUM: begin
          step  <= 5'd31;
          state <= B_ROOT;
        end
        B_ROOT: begin
          step <= step - 1'b1;
          if (step == '0) state <= B_LOAD2;
        end
        B_LOAD2: state <= B_DIV2;
        B_DIV2:  if (lane_busy == '0) state <= B_NORM;
        B_NORM:  state <= B_OUT;
        B_OUT:   if (out_ready) state <= B_IDLE;
        default: state <= B_IDLE;
      endcase
    end
  end

  // Result item, held while the receiver stalls
  assign out_valid = (state == B_OUT);
  assign out_last  = job_r.last;
  assign out_data  = {7'd0, unit_v, unit_u, tile_v, tile_u, normal_z, normal_y,
                      normal_x, pos_z, pos_y, pos_x, vertex_index};

endmodule

// File: hdl/heightmap_vertex_normal_gen_top.sv
// Heightmap vertex normal generator: top level with the configuration registers.
// Depends on hvn_pkg, hvn_front, hvn_fifo, hvn_back (and hvn_div below it).
//
// Usage:
//  - Slave stream: one height item per transfer, tuser[0] is the kind
//    (sample or flush), tdata[15:0] the signed height, 8 fraction bits.
//    Samples arrive in raster order; after the last row send grid_width
//    flush items to finish the final row.
//  - Master stream: one vertex per transfer; tlast marks the last vertex
//    caused by one input item (a row-end item gives two vertices).
//  - Configuration: cfg_we/cfg_index/cfg_data, written while idle; writing
//    a grid size restarts the grid.
//  - Flow: the front passes each item through F_IDLE and F_LEFT, and F_END
//    too at a row end, and takes no new item before it is back in F_IDLE.
//    The back works on one vertex at a time, through two passes of the
//    bit-serial divider lanes and the 32-step square root.
//  - The item that completes a vertex's neighborhood queues its job.
//  - A four-entry job queue lets the front keep accepting while a vertex
//    waits on a stalled receiver; the result holds until taken.
//  - Reset clears the counters, the queue and the sequencers and loads the
//    register defaults (2 x 2 grid, world size 1.0 on both axes).
module heightmap_vertex_normal_gen_top import hvn_pkg::*; #(
  parameter int MAX_GRID_WIDTH   = 1024,
  parameter int MAX_GRID_HEIGHT  = 1024,
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [15:0] height_sample
  input  logic [0:0]            s_tuser,   // [0] op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [19:0] vertex_index, [43:20] pos_x, [59:44] pos_y, [83:60] pos_z,
  // [99:84] normal_x, [114:100] normal_y, [130:115] normal_z,
  // [152:131] tile_u, [174:153] tile_v, [191:175] unit_u, [208:192] unit_v
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  grid_cfg_t cfg;
  logic      restart;
  logic      q_push, q_full, q_pop, q_empty;
  vtx_job_t  q_din, q_dout;

  // Grid size clamped to [2, hi], kept as size minus one
  function automatic logic [COORD_W-1:0] size_m1(input logic [10:0] v, input int hi);
    logic [COORD_W-1:0] r;
    if (v < 11'd2) r = COORD_W'(1);
    else if (int'(v) > hi) r = COORD_W'(hi - 1);
    else r = COORD_W'(v - 11'd1);
    return r;
  endfunction

  assign restart = cfg_we && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.w1  <= COORD_W'(1);
      cfg.h1  <= COORD_W'(1);
      cfg.wsx <= CFG_W'(256);
      cfg.wsz <= CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_WIDTH:  cfg.w1  <= size_m1(cfg_data[10:0], MAX_GRID_WIDTH);
        REG_GRID_HEIGHT: cfg.h1  <= size_m1(cfg_data[10:0], MAX_GRID_HEIGHT);
        REG_WORLD_X:     cfg.wsx <= cfg_data;
        REG_WORLD_Z:     cfg.wsz <= cfg_data;
      endcase
    end
  end

  hvn_front #(
    .MAX_W (MAX_GRID_WIDTH),
    .MAX_H (MAX_GRID_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .w1        (cfg.w1),
    .h1        (cfg.h1),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_op     (s_tuser[0]),
    .in_sample (s_tdata[SAMPLE_W-1:0]),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_din)
  );

  hvn_fifo u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  hvn_back #(
    .FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (!q_empty),
    .job       (q_dout),
    .job_pop   (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

// File: hdl/hvn_checker.sv
// hvn_checker: port-level assertions for the vertex normal generator, bound
// to the top level below. Depends on hvn_pkg.
module hvn_checker import hvn_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  // Reset leaves no vertex pending
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("vertex valid right after reset");

  // The front comes out of reset ready for an item
  a_reset_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

  // A stalled vertex stays offered
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("vertex withdrawn while stalled");

  // A stalled vertex keeps its payload
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
    else $error("vertex payload changed while stalled");

endmodule

bind heightmap_vertex_normal_gen_top hvn_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// File: bench/heightmap_vertex_normal_gen_top_test.sv
// Self-checking bench for heightmap_vertex_normal_gen_top: raster grids, flush rows,
// receiver stalls and grid restarts, with a built-in vertex predictor.
// Depends on hvn_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module heightmap_vertex_normal_gen_top_test;
  import hvn_pkg::*;

  localparam int VTX_W     = 209;
  localparam int NFRAC     = 14;
  localparam longint SLOPE_LIM = 64'sd2147483647;
  localparam int SETTLE    = 300;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;   // [15:0] height_sample
  logic [0:0]            s_tuser;   // [0] op
  logic                  m_tvalid;
  logic                  m_tready;
  // [19:0] vertex_index ... [208:192] unit_v
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  heightmap_vertex_normal_gen_top dut (.*);

  // Expected vertices, oldest first
  typedef struct {
    logic [VTX_W-1:0] vtx;
    logic             last;
  } vtx_exp_t;
  vtx_exp_t vertex_q[$];

  localparam int MAX_GRID_W_C = 1024;

  // Predictor state
  logic [10:0] gw_reg, gh_reg;
  logic [23:0] wsx_reg, wsz_reg;
  logic [15:0] center_row[MAX_GRID_W_C];
  logic [15:0] upper_row[MAX_GRID_W_C];
  logic [15:0] held_lower, left_center;
  int          col_cnt, row_cnt;

  int  errors;
  int  items_sent;
  bit  quiet;          // no idling on either side
  int  hold_req;       // bumped to ask for a receiver hold-off
  bit  done;

  // Field table of the packed vertex
  localparam int F_LO[11] = '{0, 20, 44, 60, 84, 100, 115, 131, 153, 175, 192};
  localparam int F_WD[11] = '{20, 24, 16, 24, 16, 15, 16, 22, 22, 17, 17};
  string f_name[11] = '{"vertex_index", "pos_x", "pos_y", "pos_z", "normal_x",
                        "normal_y", "normal_z", "tile_u", "tile_v", "unit_u", "unit_v"};

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("status: fail");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint div_near(longint n, longint d);
    longint mag, q;
    mag = n < 0 ? -n : n;
    q = (mag + d / 2) / d;
    return n < 0 ? -q : q;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint slope_q16(longint diff, longint cells, longint size, longint span);
    longint den;
    den = size * span;
    if (diff == 0) return 0;
    if (den == 0) return diff > 0 ? SLOPE_LIM : -SLOPE_LIM;
    return clampl(div_near(diff * cells * 65536, den), -SLOPE_LIM, SLOPE_LIM);
  endfunction

  function automatic longint root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic int clamp_size(logic [10:0] v);
    return v < 2 ? 2 : (v > 1024 ? 1024 : int'(v));
  endfunction

  // One vertex from its place and neighborhood
  function automatic logic [VTX_W-1:0] vertex_of(longint x, longint z, longint w, longint h,
      longint l, longint c, longint r, longint t, longint b);
    longint gx, gz, len;
    bit [63:0] idx, px, pz, nx, ny, nz, tu, tv, uu, uv, cy;
    gx = slope_q16(r - l, w - 1, wsx_reg, (x == 0 || x == w - 1) ? 1 : 2);
    gz = slope_q16(b - t, h - 1, wsz_reg, (z == 0 || z == h - 1) ? 1 : 2);
    len = root_floor(longint'(gx * gx + gz * gz + (64'sd1 << 32)));
    nx = clampl(div_near(-gx * (64'sd1 << NFRAC), len), -32767, 32767);
    nz = clampl(div_near(-gz * (64'sd1 << NFRAC), len), -32767, 32767);
    ny = clampl(div_near(64'sd1 << (16 + NFRAC), len), 0, 32767);
    px = div_near(longint'(wsx_reg) * (2 * x - (w - 1)), 2 * (w - 1));
    pz = div_near(longint'(wsz_reg) * (2 * z - (h - 1)), 2 * (h - 1));
    idx = z * w + x;
    tu = div_near(x * longint'(wsx_reg), 4 * (w - 1));
    tv = div_near(z * longint'(wsz_reg), 4 * (h - 1));
    uu = div_near(x * 65536, w - 1);
    uv = div_near(z * 65536, h - 1);
    cy = c;
    return {uv[16:0], uu[16:0], tv[21:0], tu[21:0], nz[15:0], ny[14:0], nx[15:0],
            pz[23:0], cy[15:0], px[23:0], idx[19:0]};
  endfunction

  // Advance the predictor by one accepted item, queueing its vertices
  function automatic void predict_vertices(logic op, logic [15:0] s);
    int w, h, c, r, col, n;
    bit flush;
    logic [VTX_W-1:0] v[2];
    longint cv, lv, tv, bv;
    vtx_exp_t ent;
    w = clamp_size(gw_reg);
    h = clamp_size(gh_reg);
    n = 0;
    if (col_cnt >= w || row_cnt > h) begin
      col_cnt = 0;
      row_cnt = 0;
    end
    c = col_cnt;
    r = row_cnt;
    flush = r >= h;
    if (flush != op) return;
    // vertex left of the incoming column
    if (c >= 1) begin
      col = c - 1;
      if (r >= 1) begin
        cv = sx16(center_row[col]);
        lv = col == 0 ? cv : sx16(left_center);
        tv = r == 1 ? cv : sx16(upper_row[col]);
        bv = flush ? cv : sx16(held_lower);
        v[n] = vertex_of(col, r - 1, w, h, lv, cv, sx16(center_row[c]), tv, bv);
        n++;
      end
      left_center = center_row[col];
      if (!flush) begin
        upper_row[col] = center_row[col];
        center_row[col] = held_lower;
      end
    end
    // row end: its own vertex as well
    if (c == w - 1) begin
      if (r >= 1) begin
        cv = sx16(center_row[c]);
        tv = r == 1 ? cv : sx16(upper_row[c]);
        bv = flush ? cv : sx16(s);
        v[n] = vertex_of(c, r - 1, w, h, sx16(left_center), cv, cv, tv, bv);
        n++;
      end
      if (!flush) begin
        upper_row[c] = center_row[c];
        center_row[c] = s;
      end
      col_cnt = 0;
      row_cnt = flush ? 0 : r + 1;
    end else begin
      if (!flush) held_lower = s;
      col_cnt = c + 1;
    end
    for (int i = 0; i < n; i++) begin
      ent.vtx  = v[i];
      ent.last = (i == n - 1);
      vertex_q.insert(vertex_q.size(), ent);
    end
  endfunction

  // ---------------- result checking ----------------
  function automatic void report_mismatch(string what, longint e, longint a);
    errors++;
    if (errors <= 10)
      $display("mismatch %s: expected %0h actual %0h at %0t", what, e, a, $realtime);
  endfunction

  always @(posedge clk) begin
    vtx_exp_t e;
    logic [VTX_W-1:0] mask;
    if (!rst && m_tvalid && m_tready) begin
      if (vertex_q.size() == 0) begin
        report_mismatch("unexpected vertex", 0, m_tdata[19:0]);
      end else begin
        e = vertex_q.pop_front();
        for (int i = 0; i < 11; i++) begin
          mask = (VTX_W'(1) << F_WD[i]) - 1;
          if (((e.vtx >> F_LO[i]) & mask) != ((m_tdata[VTX_W-1:0] >> F_LO[i]) & mask))
            report_mismatch(f_name[i], longint'((e.vtx >> F_LO[i]) & mask),
                            longint'((m_tdata[VTX_W-1:0] >> F_LO[i]) & mask));
        end
        if (e.last !== m_tlast) report_mismatch("last_in_run", e.last, m_tlast);
      end
    end
  end

  // ---------------- receiver ----------------
  initial begin
    int seen, hold_left;
    seen = 0;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != seen) begin
        seen = hold_req;
        hold_left = 2500;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= quiet || ($urandom_range(99) >= 33);
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  // Offer one item; returns once it is accepted, at the following falling edge
  task automatic send_item(logic op, logic [15:0] h);
    if (!quiet && $urandom_range(99) < 33) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= h;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_vertices(op, h);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    wait (vertex_q.size() == 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_GRID_WIDTH:  begin gw_reg = val[10:0]; col_cnt = 0; row_cnt = 0; end
      REG_GRID_HEIGHT: begin gh_reg = val[10:0]; col_cnt = 0; row_cnt = 0; end
      REG_WORLD_X:     wsx_reg = val;
      REG_WORLD_Z:     wsz_reg = val;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic set_grid(int w, int h, logic [23:0] wx, logic [23:0] wz);
    wait_idle();
    write_reg(REG_GRID_WIDTH, w);
    write_reg(REG_GRID_HEIGHT, h);
    write_reg(REG_WORLD_X, wx);
    write_reg(REG_WORLD_Z, wz);
  endtask

  function automatic logic [15:0] rand_height(int mode, logic [15:0] base);
    case (mode)
      0: return $urandom;
      1: return base + $urandom_range(0, 64) - 32;
      default: return $urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7FFF;
    endcase
  endfunction

  // Grid rows, flush row if all rows sent; noise inserts ignored wrong-kind items
  task automatic run_grid(int rows_to_send, int noise_pct, int mode);
    int w, h;
    logic [15:0] base;
    w = clamp_size(gw_reg);
    h = clamp_size(gh_reg);
    base = $urandom;
    for (int i = 0; i < rows_to_send * w; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(OP_FLUSH, $urandom);
      send_item(OP_SAMPLE, rand_height(mode, base));
    end
    if (rows_to_send < h) return;
    for (int i = 0; i < w; i++) begin
      if ($urandom_range(99) < noise_pct) send_item(OP_SAMPLE, $urandom);
      send_item(OP_FLUSH, $urandom);
    end
  endtask

  // ---------------- tests ----------------
  // Default 2x2 grid: field extremes, stray items of the wrong kind
  task automatic test_defaults();
    send_item(OP_FLUSH, 16'h1234);          // flush during the grid: ignored
    send_item(OP_SAMPLE, 16'h8000);
    send_item(OP_SAMPLE, 16'h7FFF);
    send_item(OP_SAMPLE, 16'h0000);
    send_item(OP_SAMPLE, 16'hFFFF);
    send_item(OP_SAMPLE, 16'h5555);         // sample during the flush: ignored
    send_item(OP_FLUSH, 16'hAAAA);
    send_item(OP_FLUSH, 16'h0000);
    wait_idle();
  endtask

  // Zero world size: saturated slopes, zero positions and tile UVs (second grid: width only)
  task automatic test_zero_world();
    set_grid(3, 3, 24'd0, 24'd0);
    run_grid(3, 0, 2);
    set_grid(3, 2, 24'd0, 24'd1);
    run_grid(2, 0, 1);
  endtask

  // Largest world sizes (one axis only in the second grid), grid sizes below the minimum
  task automatic test_extreme_world();
    set_grid(0, 1, 24'hFFFFFF, 24'hFFFFFF);
    run_grid(2, 0, 0);
    set_grid(1, 0, 24'hFFFFFF, 24'd1);
    run_grid(2, 0, 0);
  endtask

  // Widest grid (size above the maximum, clamped): one full row and the start
  // of the next; then a tall grid cut short
  task automatic test_large_grids();
    set_grid(2047, 2, 24'd1, 24'h800000);
    for (int i = 0; i < MAX_GRID_W_C + 8; i++) send_item(OP_SAMPLE, rand_height(1, 16'h0400));
    set_grid(2, 1024, 24'd4096, 24'd300);
    run_grid(4, 0, 1);
    wait_idle();
    write_reg(REG_GRID_HEIGHT, 1024);       // restart mid grid
    run_grid(3, 0, 0);
    set_grid(2, 2047, 24'd512, 24'd512);
    run_grid(2, 0, 0);
  endtask

  // Receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    set_grid(6, 5, 24'd1000, 24'd2000);
    quiet = 1'b1;
    for (int i = 0; i < 8; i++) send_item(OP_SAMPLE, rand_height(1, 16'h0100));
    hold_req++;
    run_grid(5, 0, 1);
    quiet = 1'b0;
    wait_idle();
  endtask

  // Random grids until the item budget is spent
  task automatic test_random();
    int w, h, start, rows;
    logic [23:0] wx, wz;
    start = items_sent;
    while (items_sent < 1750) begin
      quiet = (items_sent - start) > 100 && (items_sent - start) < 400;
      w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 9);
      h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 6);
      case ($urandom_range(0, 4))
        0: begin wx = $urandom_range(1, 64); wz = $urandom_range(1, 64); end
        1: begin wx = $urandom; wz = $urandom; end
        2: begin wx = $urandom_range(0, 1); wz = $urandom; end
        default: begin wx = $urandom_range(128, 8192); wz = $urandom_range(128, 8192); end
      endcase
      set_grid(w, h, wx, wz);
      rows = $urandom_range(0, 7) == 0 ? $urandom_range(1, clamp_size(h)) : clamp_size(h);
      run_grid(rows, $urandom_range(0, 1) ? 0 : 8, $urandom_range(0, 4) == 0 ? 0 :
               ($urandom_range(0, 9) == 0 ? 2 : 1));
    end
    quiet = 1'b0;
    wait_idle();
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    quiet = 1'b0;
    hold_req = 0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = OP_SAMPLE;
    cfg_we = 1'b0;
    cfg_index = REG_GRID_WIDTH;
    cfg_data = '0;
    gw_reg = 11'd2;
    gh_reg = 11'd2;
    wsx_reg = 24'd256;
    wsz_reg = 24'd256;
    held_lower = '0;
    left_center = '0;
    col_cnt = 0;
    row_cnt = 0;
    for (int i = 0; i < MAX_GRID_W_C; i++) begin
      center_row[i] = '0;
      upper_row[i] = '0;
    end
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_defaults();
    test_zero_world();
    test_extreme_world();
    test_large_grids();
    test_backpressure();
    test_random();

    wait_idle();
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
